// File: hw/rtl/base64_line_wrapping_encoder_macros.svh
// assertion macros for the base64 line wrapping encoder
// expects i_clk and i_rst_n in the scope of use

`ifndef BASE64_LINE_WRAPPING_ENCODER_MACROS_SVH
`define BASE64_LINE_WRAPPING_ENCODER_MACROS_SVH

// same-cycle implication, idle during reset
`define B64_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define B64_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/b64_pkg.sv
// shared types, constants and the symbol table of the base64 encoder
// no dependencies

package b64_pkg;

    localparam logic [7:0] LINE_LEN_RESET = 8'd76;
    localparam logic [7:0] LINE_LEN_MIN   = 8'd4;

    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // register indexes, decoded from paddr[2]
    localparam logic REG_LINE_LEN = 1'b0;
    localparam logic REG_TAB      = 1'b1;

    // group queue between front and back
    localparam int GRP_QUEUE_DEPTH = 2;
    localparam int GRP_PTR_W       = $clog2(GRP_QUEUE_DEPTH);
    localparam int GRP_CNT_W       = $clog2(GRP_QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
    } t_out_item;

    // one group of up to three bytes, fill is 1..3
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] fill;
        logic       fin;
    } t_group;

    typedef struct packed {
        logic [GRP_CNT_W-1:0] count;
        logic                 full;
        logic                 empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_CHAR,
        BK_LF,
        BK_TAB
    } t_back_state;

    // standard base64 alphabet
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return 8'h41 + w;
        end else if (v < 6'd52) begin
            return 8'h47 + w;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return CH_PLUS;
        end else begin
            return CH_SLASH;
        end
    endfunction

endpackage

// File: hw/rtl/base64_line_wrapping_encoder.sv
// Base64 encoder with line wrapping: one message byte in per transaction, one
// character out per transaction. The front takes a byte every cycle while the
// group queue is not full and packs groups of three (or a shorter final group)
// into a two-entry group queue; the back turns each group into four characters,
// one per cycle while the output register takes them, and puts a CR LF break,
// with a tab when tab_after_break is set, before a character that would
// overrun the line. The input reports full only while the group queue holds
// two groups. Each byte that closes a group causes four to seven characters,
// the last marked by run_end; other bytes cause none. A character leaves
// through an output register that refills in the cycle it is popped, so
// characters can leave every cycle; while a character waits unpopped the back
// holds. line_len below 4 behaves as 4. Configuration lives at byte address 0
// (line_len) and 4 (tab_after_break) and is to be written only while the encoder is idle.
// depends on b64_pkg, b64_front, b64_grp_fifo, b64_back and the macros header

`include "base64_line_wrapping_encoder_macros.svh"

module base64_line_wrapping_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input queue side
    input  logic               push,
    output logic               full,
    input  b64_pkg::t_in_item  i_in_item,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output b64_pkg::t_out_item o_out_item,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // configuration registers
    logic [7:0] r_line_len;
    logic       r_tab;
    logic       cfg_write;

    // front to queue
    logic               in_accept;
    logic               grp_push;
    b64_pkg::t_group    front_grp;

    // queue to back
    b64_pkg::t_group    head_grp;
    b64_pkg::t_q_status q_status;
    logic               grp_pop;

    // back to output register
    logic               back_valid;
    b64_pkg::t_out_item back_item;
    logic               out_load;

    // output register
    logic               r_out_valid;
    logic               n_out_valid;
    b64_pkg::t_out_item r_out_item;

    // assertion helpers
    logic                          last_out;
    logic                          out_is_break;
    logic                          q_grow;
    logic [b64_pkg::GRP_CNT_W-1:0] q_cnt_inc;

    // ---------------------------------------------------------------
    // configuration port, pready tied high so no access waits
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= b64_pkg::LINE_LEN_RESET;
            r_tab      <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                b64_pkg::REG_LINE_LEN: r_line_len <= pwdata[7:0];
                b64_pkg::REG_TAB:      r_tab      <= pwdata[0];
                default:               r_tab      <= r_tab;
            endcase
        end
    end

    // reads off word alignment return zero
    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                b64_pkg::REG_LINE_LEN: prdata = {24'd0, r_line_len};
                b64_pkg::REG_TAB:      prdata = {31'd0, r_tab};
                default:               prdata = 32'd0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // front: byte grouping
    // ---------------------------------------------------------------
    assign full      = q_status.full;
    assign in_accept = push && !full;

    b64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (i_in_item),
        .o_grp_push (grp_push),
        .o_grp      (front_grp)
    );

    // ---------------------------------------------------------------
    // group queue, decouples the byte rate from the character rate
    // ---------------------------------------------------------------
    b64_grp_fifo u_grp_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (grp_push),
        .i_grp    (front_grp),
        .i_pop    (grp_pop),
        .o_grp    (head_grp),
        .o_status (q_status)
    );

    // ---------------------------------------------------------------
    // back: character sequencer with line wrapping
    // ---------------------------------------------------------------
    b64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (!q_status.empty),
        .i_grp       (head_grp),
        .i_line_len  (r_line_len),
        .i_tab       (r_tab),
        .i_out_ready (out_load),
        .o_grp_pop   (grp_pop),
        .o_out_valid (back_valid),
        .o_out_item  (back_item)
    );

    // ---------------------------------------------------------------
    // output register: refills in the cycle its character is popped
    // ---------------------------------------------------------------
    assign out_load = !r_out_valid || pop;

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = back_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && back_valid) begin
            r_out_item <= back_item;
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_item = r_out_item;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    assign last_out     = !empty && o_out_item.run_end;
    assign out_is_break = (o_out_item.out_char == b64_pkg::CH_CR)
                          || (o_out_item.out_char == b64_pkg::CH_LF)
                          || (o_out_item.out_char == b64_pkg::CH_TAB);
    assign q_grow       = grp_push && !grp_pop && !q_status.full;
    assign q_cnt_inc    = q_status.count + 1'b1;

    // the character marked run_end is always a symbol or a pad
    `B64_ASSERT_IMPL(a_run_end_not_break, last_out, !out_is_break, "run_end on a break character")

    // a group pushed without a pop grows the queue by one
    `B64_ASSERT_NEXT(a_queue_grows, q_grow, q_status.count == $past(q_cnt_inc), "group push lost")

endmodule

// File: hw/rtl/b64_front.sv
// front part: gathers bytes into groups of three, or a shorter final group, and hands them on
// depends on b64_pkg

module b64_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  b64_pkg::t_in_item i_item,
    output logic              o_grp_push,
    output b64_pkg::t_group   o_grp
);

    logic [15:0] r_held;
    logic [15:0] n_held;
    logic [1:0]  r_fill;
    logic [1:0]  n_fill;
    logic [1:0]  fill_inc;

    assign fill_inc = r_fill + 2'd1;

    always_comb begin
        o_grp.fill = fill_inc;
        o_grp.fin  = i_item.final_byte;
        o_grp.b0   = r_held[15:8];
        o_grp.b1   = r_held[7:0];
        o_grp.b2   = i_item.in_byte;
        unique case (r_fill)
            2'd0: begin
                o_grp.b0 = i_item.in_byte;
                o_grp.b1 = 8'd0;
                o_grp.b2 = 8'd0;
            end
            2'd1: begin
                o_grp.b1 = i_item.in_byte;
                o_grp.b2 = 8'd0;
            end
            default: begin
                o_grp.fill = 2'd3;
            end
        endcase
    end

    // a group leaves when it is full or the message ends
    assign o_grp_push = i_accept && ((r_fill == 2'd2) || i_item.final_byte);

    always_comb begin
        n_held = r_held;
        n_fill = r_fill;
        if (o_grp_push) begin
            n_held = 16'd0;
            n_fill = 2'd0;
        end else if (i_accept) begin
            n_held = {o_grp.b0, o_grp.b1};
            n_fill = fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 16'd0;
            r_fill <= 2'd0;
        end else begin
            r_held <= n_held;
            r_fill <= n_fill;
        end
    end

endmodule

// File: hw/rtl/b64_grp_fifo.sv
// short queue of groups between front and back
// depends on b64_pkg

module b64_grp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64_pkg::t_group     i_grp,
    input  logic                i_pop,
    output b64_pkg::t_group     o_grp,
    output b64_pkg::t_q_status  o_status
);

    b64_pkg::t_group r_mem [b64_pkg::GRP_QUEUE_DEPTH];

    logic [b64_pkg::GRP_PTR_W-1:0] r_wr_ptr;
    logic [b64_pkg::GRP_PTR_W-1:0] r_rd_ptr;
    logic [b64_pkg::GRP_CNT_W-1:0] r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_status.count = r_count;
    assign o_status.full  = (r_count == b64_pkg::GRP_CNT_W'(b64_pkg::GRP_QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_grp   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == b64_pkg::GRP_PTR_W'(b64_pkg::GRP_QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == b64_pkg::GRP_PTR_W'(b64_pkg::GRP_QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/b64_back.sv
// back part: turns a group into characters, inserting line breaks
// depends on b64_pkg

module b64_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_grp_valid,
    input  b64_pkg::t_group    i_grp,
    input  logic [7:0]         i_line_len,
    input  logic               i_tab,
    input  logic               i_out_ready,
    output logic               o_grp_pop,
    output logic               o_out_valid,
    output b64_pkg::t_out_item o_out_item
);

    b64_pkg::t_back_state r_state;
    b64_pkg::t_back_state n_state;
    logic [1:0]           r_sym_idx;
    logic [1:0]           n_sym_idx;
    logic [7:0]           r_line_count;
    logic [7:0]           n_line_count;

    logic [7:0] lim;
    logic       need_break;
    logic       advance;
    logic [7:0] sym_char;

    assign lim        = (i_line_len < b64_pkg::LINE_LEN_MIN) ? b64_pkg::LINE_LEN_MIN
                                                             : i_line_len;
    assign need_break = (r_line_count >= lim);
    assign advance    = o_out_valid && i_out_ready;

    // pick the sextet, padding the tail of a short group
    always_comb begin
        unique case (r_sym_idx)
            2'd0: sym_char = b64_pkg::sym(i_grp.b0[7:2]);
            2'd1: sym_char = b64_pkg::sym({i_grp.b0[1:0], i_grp.b1[7:4]});
            2'd2: sym_char = (i_grp.fill >= 2'd2)
                             ? b64_pkg::sym({i_grp.b1[3:0], i_grp.b2[7:6]})
                             : b64_pkg::CH_PAD;
            default: sym_char = (i_grp.fill == 2'd3) ? b64_pkg::sym(i_grp.b2[5:0])
                                                     : b64_pkg::CH_PAD;
        endcase
    end

    // outputs
    always_comb begin
        o_out_valid         = 1'b0;
        o_grp_pop           = 1'b0;
        o_out_item.out_char = sym_char;
        o_out_item.run_end  = 1'b0;
        unique case (r_state)
            b64_pkg::BK_CHAR: begin
                if (i_grp_valid) begin
                    o_out_valid = 1'b1;
                    if (need_break) begin
                        o_out_item.out_char = b64_pkg::CH_CR;
                    end else begin
                        o_out_item.run_end = (r_sym_idx == 2'd3);
                        o_grp_pop          = i_out_ready && (r_sym_idx == 2'd3);
                    end
                end
            end
            b64_pkg::BK_LF: begin
                o_out_valid         = 1'b1;
                o_out_item.out_char = b64_pkg::CH_LF;
            end
            b64_pkg::BK_TAB: begin
                o_out_valid         = 1'b1;
                o_out_item.out_char = b64_pkg::CH_TAB;
            end
            default: begin
                o_out_valid = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state      = r_state;
        n_sym_idx    = r_sym_idx;
        n_line_count = r_line_count;
        unique case (r_state)
            b64_pkg::BK_CHAR: begin
                if (advance) begin
                    if (need_break) begin
                        n_state      = b64_pkg::BK_LF;
                        n_line_count = 8'd0;
                    end else begin
                        n_line_count = r_line_count + 8'd1;
                        n_sym_idx    = r_sym_idx + 2'd1;
                        if ((r_sym_idx == 2'd3) && i_grp.fin) begin
                            n_line_count = 8'd0;
                        end
                    end
                end
            end
            b64_pkg::BK_LF: begin
                if (advance) begin
                    n_state = i_tab ? b64_pkg::BK_TAB : b64_pkg::BK_CHAR;
                end
            end
            b64_pkg::BK_TAB: begin
                if (advance) begin
                    n_state = b64_pkg::BK_CHAR;
                end
            end
            default: begin
                n_state = b64_pkg::BK_CHAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= b64_pkg::BK_CHAR;
            r_sym_idx    <= 2'd0;
            r_line_count <= 8'd0;
        end else begin
            r_state      <= n_state;
            r_sym_idx    <= n_sym_idx;
            r_line_count <= n_line_count;
        end
    end

endmodule

// File: bench/testbench.sv
// self-checking bench for base64_line_wrapping_encoder: directed and random messages under several line formats
// holds its own character-stream model inside a small scoreboard class
// depends on b64_pkg and the encoder rtl

module testbench;
    import b64_pkg::*;

    // ------------------------------------------------------------------
    // scoreboard: predicts the character stream and checks each popped char
    // ------------------------------------------------------------------
    class char_stream_model;
        logic [7:0]  line_len;
        logic        tab_on;
        logic [15:0] held;
        logic [1:0]  fill;
        logic [7:0]  line_count;
        t_out_item   burst[$];
        t_out_item   pending_chars[$];
        int          mismatches;
        int          chars_checked;
        int          bytes_taken;
        int          breaks_seen;

        function void clear();
            line_len   = LINE_LEN_RESET;
            tab_on     = 1'b0;
            held       = '0;
            fill       = '0;
            line_count = '0;
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch at %0t: %s, expected 0x%0h got 0x%0h", $time, what, want, got);
            end
        endfunction

        function logic [7:0] symbol_of(logic [5:0] v);
            string alphabet;
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            return alphabet[v];
        endfunction

        // one character, preceded by a break when the line is already full
        function void place(logic [7:0] c);
            t_out_item  o;
            logic [7:0] lim;
            lim       = (line_len < LINE_LEN_MIN) ? LINE_LEN_MIN : line_len;
            o.run_end = 1'b0;
            if (line_count >= lim) begin
                o.out_char = CH_CR;
                burst.push_back(o);
                o.out_char = CH_LF;
                burst.push_back(o);
                if (tab_on) begin
                    o.out_char = CH_TAB;
                    burst.push_back(o);
                end
                line_count = 8'd1;
                breaks_seen++;
            end else begin
                line_count = line_count + 8'd1;
            end
            o.out_char = c;
            burst.push_back(o);
        endfunction

        function void take_byte(t_in_item it);
            logic [7:0] b0;
            logic [7:0] b1;
            logic [7:0] b2;
            logic [2:0] n_fill;
            t_out_item  last;
            bytes_taken++;
            n_fill = {1'b0, fill} + 3'd1;
            if (n_fill == 3'd1) begin
                b0 = it.in_byte;
                b1 = '0;
                b2 = '0;
            end else if (n_fill == 3'd2) begin
                b0 = held[15:8];
                b1 = it.in_byte;
                b2 = '0;
            end else begin
                b0 = held[15:8];
                b1 = held[7:0];
                b2 = it.in_byte;
            end
            if (n_fill < 3'd3 && !it.final_byte) begin
                held = {b0, b1};
                fill = n_fill[1:0];
                return;
            end
            burst.delete();
            place(symbol_of(b0[7:2]));
            place(symbol_of({b0[1:0], b1[7:4]}));
            place((n_fill >= 3'd2) ? symbol_of({b1[3:0], b2[7:6]}) : CH_PAD);
            place((n_fill == 3'd3) ? symbol_of(b2[5:0]) : CH_PAD);
            held = '0;
            fill = '0;
            if (it.final_byte) line_count = '0;
            last         = burst.pop_back();
            last.run_end = 1'b1;
            burst.push_back(last);
            foreach (burst[k]) pending_chars.push_back(burst[k]);
        endfunction

        function void match_char(t_out_item got);
            t_out_item want;
            if (pending_chars.size() == 0) begin
                flag("character with nothing pending", 0, got);
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (got.out_char !== want.out_char) flag("out_char", want.out_char, got.out_char);
            if (got.run_end !== want.run_end) flag("run_end", want.run_end, got.run_end);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // signals and the encoder
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    in_item;
    logic        empty;
    logic        pop;
    t_out_item   out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    char_stream_model sb;
    bit               tx_steady;
    bit               rx_steady;
    int               formats_used;

    base64_line_wrapping_encoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = ~i_clk;
    end

    // idle length between transactions: mostly none or short, now and then long
    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // input side: inputs move on the falling edge, acceptance seen on the rising edge
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic fin);
        int       gap;
        t_in_item it;
        gap           = pick_gap(tx_steady);
        it.in_byte    = b;
        it.final_byte = fin;
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        // push stays high across back-to-back transactions, only the data changes
        push    <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (full);
        sb.take_byte(it);
    endtask

    task automatic send_message(int len);
        for (int k = 0; k < len; k++) send_byte(8'($urandom), k == len - 1);
    endtask

    task automatic send_list(logic [7:0] bytes[]);
        foreach (bytes[k]) send_byte(bytes[k], k == bytes.size() - 1);
    endtask

    // lower push and hold off until every predicted character has been popped
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    task automatic reg_access(logic sel, logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read both registers back and compare with the model's copy
    task automatic check_regs();
        logic [31:0] rd;
        reg_access(REG_LINE_LEN, 1'b0, '0, rd);
        if (rd[7:0] !== sb.line_len) sb.flag("line_len readback", sb.line_len, rd[7:0]);
        reg_access(REG_TAB, 1'b0, '0, rd);
        if (rd[0] !== sb.tab_on) sb.flag("tab_after_break readback", sb.tab_on, rd[0]);
    endtask

    // only called with the encoder idle and no message open
    task automatic set_line_format(logic [7:0] len, logic tab);
        logic [31:0] rd;
        drain();
        // extra idle margin before the registers are written
        repeat (12) @(posedge i_clk);
        reg_access(REG_LINE_LEN, 1'b1, {24'h0, len}, rd);
        sb.line_len = len;
        reg_access(REG_TAB, 1'b1, {31'h0, tab}, rd);
        sb.tab_on = tab;
        check_regs();
        formats_used++;
    endtask

    // random message length: mostly short, sometimes a few lines' worth
    function automatic int pick_len(int room);
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, 10);
        else if (r < 95) len = $urandom_range(11, 40);
        else len = $urandom_range(41, 120);
        return (len > room) ? room : len;
    endfunction

    task automatic random_phase(int budget, bit pause_midway);
        int sent;
        sent = 0;
        while (sent < budget) begin
            int len;
            len = pick_len(budget - sent);
            send_message(len);
            sent += len;
            // sender holds off with the encoder fully drained once per such phase
            if (pause_midway && sent >= budget / 2) begin
                drain();
                pause_midway = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side: pop idles at random, every popped transaction is checked
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_rst_n);
        forever begin
            int gap;
            gap = pick_gap(rx_steady);
            @(negedge i_clk);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.match_char(out_item);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] msg[];
        sb = new();
        sb.clear();
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        formats_used = 1;
        i_rst_n = 1'b0;
        push    = 1'b0;
        in_item = '0;
        pop     = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of both registers
        check_regs();

        // directed: single byte with two pads, two bytes with one pad
        msg = '{8'h00};
        send_list(msg);
        msg = '{8'hFF, 8'hFF};
        send_list(msg);
        // group completed by the final byte, all '+'
        msg = '{8'hFB, 8'hEF, 8'hBE};
        send_list(msg);
        // all '/' followed by a padded final group
        msg = '{8'hFF, 8'hFF, 8'hFF, 8'h80};
        send_list(msg);
        // shortest line with tab folding, pads land after a break
        set_line_format(8'd4, 1'b1);
        msg = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04};
        send_list(msg);
        // line_len of zero behaves as the minimum
        set_line_format(8'd0, 1'b0);
        msg = '{8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h7F};
        send_list(msg);

        // widest line: one long message crosses it once
        set_line_format(8'd255, 1'b1);
        send_message(195);

        set_line_format(LINE_LEN_RESET, 1'b0);
        random_phase(40, 1'b0);

        set_line_format(8'd4, 1'b1);
        random_phase(40, 1'b1);

        // a stretch with neither side idling
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        set_line_format(8'd0, 1'b0);
        random_phase(40, 1'b0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        set_line_format(8'($urandom_range(4, 20)), 1'($urandom));
        random_phase(40, 1'b0);

        set_line_format(8'd3, 1'b1);
        random_phase(40, 1'b0);

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d bytes and %0d characters, %0d line breaks", sb.bytes_taken,
                 sb.chars_checked, sb.breaks_seen);
        $display("ran under %0d line formats, %0d mismatches", formats_used, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(12 * 600000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/b64_pkg.sv
hw/rtl/b64_front.sv
hw/rtl/b64_grp_fifo.sv
hw/rtl/b64_back.sv
hw/rtl/base64_line_wrapping_encoder.sv
bench/testbench.sv
